// File: src/ldwt_pkg.sv
// Shared constants and types for the 5/3 lifting line unit.
package ldwt_pkg;

  // Most coefficients that one sample can release (low, high and the end flush).
  localparam int RES_MAX = 3;

  // Result queue depth: room for one full burst of coefficients plus one more entry.
  localparam int QUEUE_DEPTH = 4;

  typedef logic [$clog2(QUEUE_DEPTH)-1:0]   qptr_t;
  typedef logic [$clog2(QUEUE_DEPTH+1)-1:0] qcnt_t;
  typedef logic [$clog2(RES_MAX+1)-1:0]     nres_t;

endpackage

// File: src/lifting_dwt53_forward_line_unit.sv
// Forward reversible 5/3 lifting wavelet over one streamed line.
//
//  channel | direction | request carries                      | handshake
//  --------+-----------+--------------------------------------+----------------------
//  in_     | input     | in_sample, in_line_end               | in_valid / in_ready
//  out_    | output    | out_coeff, out_is_high, out_line_done | out_valid / out_ready
//  cfg_    | input     | cfg_odd_start                        | cfg_valid / cfg_ready
//
// A sample is taken into the input register, then lifted combinationally by adds and shifts on a
// two-sample window, and its zero to three coefficients are written together into a four-entry
// result queue whose head drives the output ports.
// Sustained rate is one sample per cycle while the result queue has room; a coefficient is
// written into the queue when the sample that releases it leaves the input register.
// The input stage waits only while the queue lacks room for the coefficients of the waiting
// sample.
// Reset (rst_n low, synchronous) empties the pipeline and queue, clears the line position
// and sets odd_start to zero.
module lifting_dwt53_forward_line_unit #(
  parameter int MAX_LINE    = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_line_end,
  // Coefficient output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS:0]   out_coeff,
  output logic                          out_is_high,
  output logic                          out_line_done,
  // Configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_odd_start
);

  localparam int PW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int EW = SAMPLE_BITS + 3;
  localparam logic [PW-1:0] LastPos = PW'(MAX_LINE - 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] coeff;
    logic                        is_high;
    logic                        done;
  } res_t;

  // Configuration and input stage registers
  logic                          odd_start_r;
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_end_r;

  // Line state
  logic [PW-1:0]                 pos_r;
  logic signed [SAMPLE_BITS-1:0] win0_r;
  logic signed [SAMPLE_BITS-1:0] win1_r;
  logic signed [SAMPLE_BITS:0]   prior_r;
  logic signed [SAMPLE_BITS:0]   prior_nxt;

  // Result queue
  res_t                q_r [ldwt_pkg::QUEUE_DEPTH];
  ldwt_pkg::qptr_t     wr_ptr_r;
  ldwt_pkg::qptr_t     rd_ptr_r;
  ldwt_pkg::qcnt_t     cnt_r;
  ldwt_pkg::qcnt_t     free_slots;

  logic                in_take;
  logic                pop;
  logic                fire;
  logic                line_end;
  logic                first_pos;
  logic                prev_high;
  logic [PW+1:0]       pos_x;
  ldwt_pkg::nres_t     res_n;
  res_t                res [ldwt_pkg::RES_MAX];

  // Lifting arithmetic, all in EW bits
  logic signed [EW-1:0] x_e;
  logic signed [EW-1:0] dbl_e;
  logic signed [EW-1:0] s1_e;
  logic signed [EW-1:0] s2_e;
  logic signed [EW-1:0] left_e;
  logic signed [EW-1:0] h_e;
  logic signed [EW-1:0] h_ext;
  logic signed [EW-1:0] hl_e;
  logic signed [EW-1:0] low_e;
  logic signed [EW-1:0] flush_e;
  logic signed [EW-1:0] hk_e;
  logic signed [EW-1:0] hk_ext;
  logic signed [EW-1:0] hkl_e;
  logic signed [EW-1:0] lowk_e;
  logic signed [SAMPLE_BITS:0] h_c;
  logic signed [SAMPLE_BITS:0] hk_c;

  // Handshakes; the waiting sample leaves once the queue can take all of its coefficients.
  assign cfg_ready  = 1'b1;
  assign pop        = out_valid && out_ready;
  assign free_slots = ldwt_pkg::qcnt_t'(ldwt_pkg::QUEUE_DEPTH) - cnt_r
                      + ldwt_pkg::qcnt_t'(pop);
  assign fire       = s1_valid_r && (free_slots >= ldwt_pkg::qcnt_t'(res_n));
  assign in_ready   = !s1_valid_r || fire;
  assign in_take    = in_valid && in_ready;

  // Position decode; a line that reaches its maximum length ends there.
  assign pos_x     = {2'b00, pos_r};
  assign first_pos = (pos_r == '0);
  assign line_end  = s1_end_r || (pos_r == LastPos);
  assign prev_high = (~pos_r[0]) ^ odd_start_r;

  // Predict step for the high-pass position before the new sample.
  assign x_e    = {{3{s1_sample_r[SAMPLE_BITS-1]}}, s1_sample_r};
  assign dbl_e  = x_e + x_e;
  assign s1_e   = {{3{win0_r[SAMPLE_BITS-1]}}, win0_r};
  assign s2_e   = {{3{win1_r[SAMPLE_BITS-1]}}, win1_r};
  assign left_e = (pos_x >= (PW+2)'(2)) ? s2_e : x_e;
  assign h_e    = s1_e - ((left_e + x_e) >>> 1);
  assign h_c    = h_e[SAMPLE_BITS:0];
  assign h_ext  = {{2{h_c[SAMPLE_BITS]}}, h_c};

  // Update step for the low-pass neighbours of that high-pass value.
  assign hl_e    = (pos_x >= (PW+2)'(3)) ? {{2{prior_r[SAMPLE_BITS]}}, prior_r} : h_ext;
  assign low_e   = s2_e + ((hl_e + h_ext + EW'(2)) >>> 2);
  assign flush_e = x_e + ((h_ext + h_ext + EW'(2)) >>> 2);

  // A line ending on a high-pass sample: its right neighbour clamps to the left one.
  assign hk_e   = x_e - s1_e;
  assign hk_c   = hk_e[SAMPLE_BITS:0];
  assign hk_ext = {{2{hk_c[SAMPLE_BITS]}}, hk_c};
  assign hkl_e  = (pos_x >= (PW+2)'(2)) ? {{2{prior_r[SAMPLE_BITS]}}, prior_r} : hk_ext;
  assign lowk_e = s1_e + ((hkl_e + hk_ext + EW'(2)) >>> 2);

  // Select the coefficients that this sample releases, in position order.
  always_comb begin
    res_n     = '0;
    prior_nxt = prior_r;
    for (int i = 0; i < ldwt_pkg::RES_MAX; i++) begin
      res[i] = '0;
    end
    if (first_pos) begin
      if (line_end) begin
        res_n = ldwt_pkg::nres_t'(1);
        if (odd_start_r) begin
          res[0] = '{coeff: dbl_e[SAMPLE_BITS:0], is_high: 1'b1, done: 1'b1};
        end else begin
          res[0] = '{coeff: x_e[SAMPLE_BITS:0], is_high: 1'b0, done: 1'b1};
        end
      end
    end else if (prev_high) begin
      prior_nxt = h_c;
      if (pos_x >= (PW+2)'(2)) begin
        res[0] = '{coeff: low_e[SAMPLE_BITS:0], is_high: 1'b0, done: 1'b0};
        res[1] = '{coeff: h_c, is_high: 1'b1, done: 1'b0};
        res[2] = '{coeff: flush_e[SAMPLE_BITS:0], is_high: 1'b0, done: 1'b1};
        res_n  = line_end ? ldwt_pkg::nres_t'(3) : ldwt_pkg::nres_t'(2);
      end else begin
        res[0] = '{coeff: h_c, is_high: 1'b1, done: 1'b0};
        res[1] = '{coeff: flush_e[SAMPLE_BITS:0], is_high: 1'b0, done: 1'b1};
        res_n  = line_end ? ldwt_pkg::nres_t'(2) : ldwt_pkg::nres_t'(1);
      end
    end else if (line_end) begin
      prior_nxt = hk_c;
      res[0] = '{coeff: lowk_e[SAMPLE_BITS:0], is_high: 1'b0, done: 1'b0};
      res[1] = '{coeff: hk_c, is_high: 1'b1, done: 1'b1};
      res_n  = ldwt_pkg::nres_t'(2);
    end
  end

  // Control registers: configuration, input stage, line position, last high-pass value
  // and queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_start_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      prior_r     <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        odd_start_r <= cfg_odd_start;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        pos_r    <= line_end ? '0 : pos_r + PW'(1);
        prior_r  <= prior_nxt;
        wr_ptr_r <= wr_ptr_r + ldwt_pkg::qptr_t'(res_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ldwt_pkg::qptr_t'(1);
      end
      cnt_r <= cnt_r + (fire ? ldwt_pkg::qcnt_t'(res_n) : '0) - ldwt_pkg::qcnt_t'(pop);
    end
  end

  // Data registers: input sample, sample window and queue entries.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample;
      s1_end_r    <= in_line_end;
    end
    if (fire) begin
      win0_r  <= s1_sample_r;
      win1_r  <= win0_r;
      for (int i = 0; i < ldwt_pkg::RES_MAX; i++) begin
        if (ldwt_pkg::nres_t'(i) < res_n) begin
          q_r[wr_ptr_r + ldwt_pkg::qptr_t'(i)] <= res[i];
        end
      end
    end
  end

  // Queue head drives the result ports.
  assign out_valid     = (cnt_r != '0);
  assign out_coeff     = q_r[rd_ptr_r].coeff;
  assign out_is_high   = q_r[rd_ptr_r].is_high;
  assign out_line_done = q_r[rd_ptr_r].done;

endmodule

// File: src/ldwt_checker.sv
// Port-level checker for the 5/3 lifting line unit, bound to the top level.
module ldwt_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS:0]   out_coeff,
  input logic                          out_is_high,
  input logic                          out_line_done
);

  // Reset empties the result queue.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present right after reset");

  // A stalled result request is not withdrawn.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request withdrawn while stalled");

  // A stalled result request keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_coeff) && $stable(out_is_high) && $stable(out_line_done))
    else $error("result payload changed while stalled");

  // Input back-pressure only arises from coefficients waiting in the queue.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind lifting_dwt53_forward_line_unit ldwt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ldwt_checker (.*);
